// ===== hw/rtl/bchc_pkg.sv =====
// Package with types, constants and helpers for the button click/hold classifier.
package bchc_pkg;

    // Counter width and saturation limit of the hold and gap counters.
    localparam int unsigned CNT_W       = 14;
    localparam logic [CNT_W-1:0] COUNT_LIMIT = 14'd9999;

    // Configuration register widths.
    localparam int unsigned MIN_W   = 9;
    localparam int unsigned SHORT_W = 10;

    // Configuration port geometry.
    localparam int unsigned ADDR_W  = 5;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned INDEX_W = 3;

    // Register indexes on the configuration port.
    localparam logic [INDEX_W-1:0] REG_UPDOWN_LONG = 3'd0;
    localparam logic [INDEX_W-1:0] REG_QUIT_HOLD   = 3'd1;
    localparam logic [INDEX_W-1:0] REG_MIN_CLICK   = 3'd2;
    localparam logic [INDEX_W-1:0] REG_SHORT_MAX   = 3'd3;
    localparam logic [INDEX_W-1:0] REG_DOUBLE_GAP  = 3'd4;

    // Register reset values.
    localparam logic [CNT_W-1:0]   UPDOWN_LONG_RST = 14'd1000;
    localparam logic [CNT_W-1:0]   QUIT_HOLD_RST   = 14'd3000;
    localparam logic [MIN_W-1:0]   MIN_CLICK_RST   = 9'd20;
    localparam logic [SHORT_W-1:0] SHORT_MAX_RST   = 10'd500;
    localparam logic [CNT_W-1:0]   DOUBLE_GAP_RST  = 14'd200;

    // Click stage of the OK key.
    typedef enum logic [1:0] {
        STAGE_IDLE  = 2'd0,
        STAGE_ONE   = 2'd1,
        STAGE_TWO   = 2'd2,
        STAGE_THREE = 2'd3
    } click_stage_t;

    // One tick: three active-low key levels.
    typedef struct packed {
        logic ok_level;
        logic up_level;
        logic down_level;
    } tick_t;

    // Events recognized in one tick.
    typedef struct packed {
        logic enter_event;
        logic quit_event;
        logic double_click_event;
        logic up_long_event;
        logic down_long_event;
    } events_t;

    // Increment that saturates at the limit, also where the sum would wrap at the counter width.
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] s;
        s = v + 1'b1;
        if (s > COUNT_LIMIT || s == '0)
        begin
            s = COUNT_LIMIT;
        end
        return s;
    endfunction

endpackage

// ===== hw/rtl/button_click_hold_classifier.sv =====
// Top level of the button click/hold classifier with its configuration registers.
//
//  channel   direction  handshake               payload
//  tick      in         tick_valid/tick_stall   tick_t   (ok, up, down levels)
//  events    out        event_valid/event_stall events_t (five one-tick pulses)
//  config    in         APB psel/penable/pready five threshold registers
//
// One tick transaction is taken per clock cycle while tick_stall is low; its events appear in the next cycle.
// The whole tick update is one pass of compare-and-increment logic on the state registers.
// Reset clears the arm, the counters and the click stage and loads the register defaults.
// A stalled event transaction holds the result register and stalls the tick input.
module button_click_hold_classifier (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     tick_valid,
    output logic                     tick_stall,
    input  bchc_pkg::tick_t          tick,
    output logic                     event_valid,
    input  logic                     event_stall,
    output bchc_pkg::events_t        events,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [bchc_pkg::ADDR_W-1:0] paddr,
    input  logic [bchc_pkg::DATA_W-1:0] pwdata,
    output logic [bchc_pkg::DATA_W-1:0] prdata,
    output logic                     pready
);
    import bchc_pkg::*;

    // Configuration registers.
    logic [CNT_W-1:0]   updown_long_reg;
    logic [CNT_W-1:0]   quit_hold_reg;
    logic [MIN_W-1:0]   min_click_reg;
    logic [SHORT_W-1:0] short_max_reg;
    logic [CNT_W-1:0]   double_gap_reg;

    // Tick state.
    logic               ok_armed_reg,    ok_armed_next;
    logic [CNT_W-1:0]   hold_count_reg,  hold_count_next;
    logic [CNT_W-1:0]   gap_count_reg,   gap_count_next;
    click_stage_t       click_stage_reg, click_stage_next;

    // Result register.
    logic               event_valid_reg;
    events_t            events_reg, events_next;

    logic               tick_accept;
    logic               cfg_write;
    logic [INDEX_W-1:0] cfg_index;
    logic               ok_p, up_p, down_p;
    logic [CNT_W-1:0]   short_ext, min_ext;

    assign pready      = 1'b1;
    assign cfg_write   = psel && penable && pwrite;
    assign cfg_index   = paddr[ADDR_W-1:2];
    assign tick_stall  = event_valid_reg && event_stall;
    assign tick_accept = tick_valid && !tick_stall;
    assign event_valid = event_valid_reg;
    assign events      = events_reg;

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            updown_long_reg <= UPDOWN_LONG_RST;
            quit_hold_reg   <= QUIT_HOLD_RST;
            min_click_reg   <= MIN_CLICK_RST;
            short_max_reg   <= SHORT_MAX_RST;
            double_gap_reg  <= DOUBLE_GAP_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_UPDOWN_LONG: updown_long_reg <= pwdata[CNT_W-1:0];
                REG_QUIT_HOLD:   quit_hold_reg   <= pwdata[CNT_W-1:0];
                REG_MIN_CLICK:   min_click_reg   <= pwdata[MIN_W-1:0];
                REG_SHORT_MAX:   short_max_reg   <= pwdata[SHORT_W-1:0];
                REG_DOUBLE_GAP:  double_gap_reg  <= pwdata[CNT_W-1:0];
                default:         ;
            endcase
        end
    end

    // Configuration register reads.
    always_comb
    begin
        unique case (cfg_index)
            REG_UPDOWN_LONG: prdata = DATA_W'(updown_long_reg);
            REG_QUIT_HOLD:   prdata = DATA_W'(quit_hold_reg);
            REG_MIN_CLICK:   prdata = DATA_W'(min_click_reg);
            REG_SHORT_MAX:   prdata = DATA_W'(short_max_reg);
            REG_DOUBLE_GAP:  prdata = DATA_W'(double_gap_reg);
            default:         prdata = '0;
        endcase
    end

    // Tick update: OK key classification first, then up, then down.
    always_comb
    begin
        ok_p      = !tick.ok_level;
        up_p      = !tick.up_level;
        down_p    = !tick.down_level;
        short_ext = CNT_W'(short_max_reg);
        min_ext   = CNT_W'(min_click_reg);

        events_next      = '0;
        ok_armed_next    = ok_armed_reg || ok_p;
        hold_count_next  = hold_count_reg;
        click_stage_next = click_stage_reg;

        // The gap counter runs only while a click is pending.
        if (click_stage_reg != STAGE_IDLE)
        begin
            gap_count_next = sat_inc(gap_count_reg);
        end
        else
        begin
            gap_count_next = '0;
        end

        if (ok_armed_next)
        begin
            if (ok_p)
            begin
                // Key held: count and check the quit threshold.
                hold_count_next = sat_inc(hold_count_reg);
                if (hold_count_next == quit_hold_reg)
                begin
                    events_next.quit_event = 1'b1;
                    click_stage_next       = STAGE_IDLE;
                    ok_armed_next          = 1'b0;
                end
                if (click_stage_next == STAGE_ONE)
                begin
                    click_stage_next = STAGE_TWO;
                end
            end
            else
            begin
                // Key released: classify the hold length.
                if (hold_count_reg < short_ext && hold_count_reg > min_ext)
                begin
                    if (click_stage_reg == STAGE_IDLE)
                    begin
                        click_stage_next = STAGE_ONE;
                    end
                end
                else if (hold_count_reg > short_ext && hold_count_reg < quit_hold_reg)
                begin
                    if (click_stage_reg != STAGE_ONE)
                    begin
                        events_next.enter_event = 1'b1;
                        gap_count_next          = '0;
                        hold_count_next         = '0;
                        click_stage_next        = STAGE_IDLE;
                        ok_armed_next           = 1'b0;
                    end
                end
                else
                begin
                    hold_count_next = '0;
                end

                // Gap long enough: resolve the pending clicks.
                if (gap_count_next > double_gap_reg)
                begin
                    unique case (click_stage_next)
                        STAGE_ONE:
                        begin
                            events_next.enter_event = 1'b1;
                            gap_count_next          = '0;
                            hold_count_next         = '0;
                            click_stage_next        = STAGE_IDLE;
                            ok_armed_next           = 1'b0;
                        end
                        STAGE_TWO:
                        begin
                            events_next.double_click_event = 1'b1;
                            gap_count_next                 = '0;
                            hold_count_next                = '0;
                            click_stage_next               = STAGE_IDLE;
                            ok_armed_next                  = 1'b0;
                        end
                        default:
                        begin
                            ok_armed_next = 1'b0;
                        end
                    endcase
                end
            end
        end

        // Up key long press on the shared hold counter.
        if (up_p)
        begin
            if (hold_count_next <= updown_long_reg)
            begin
                hold_count_next = sat_inc(hold_count_next);
            end
            else
            begin
                hold_count_next           = '0;
                events_next.up_long_event = 1'b1;
            end
        end

        // Down key long press, after up in the same tick.
        if (down_p)
        begin
            if (hold_count_next <= updown_long_reg)
            begin
                hold_count_next = sat_inc(hold_count_next);
            end
            else
            begin
                hold_count_next             = '0;
                events_next.down_long_event = 1'b1;
            end
        end
    end

    // State update on each accepted tick transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ok_armed_reg    <= 1'b0;
            hold_count_reg  <= '0;
            gap_count_reg   <= '0;
            click_stage_reg <= STAGE_IDLE;
        end
        else if (tick_accept)
        begin
            ok_armed_reg    <= ok_armed_next;
            hold_count_reg  <= hold_count_next;
            gap_count_reg   <= gap_count_next;
            click_stage_reg <= click_stage_next;
        end
    end

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            event_valid_reg <= 1'b0;
        end
        else if (tick_accept)
        begin
            event_valid_reg <= 1'b1;
        end
        else if (!event_stall)
        begin
            event_valid_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (tick_accept)
        begin
            events_reg <= events_next;
        end
    end

`ifndef SYNTHESIS
    // Every accepted tick leaves a result transaction behind.
    assert property (@(posedge clk) disable iff (!rst_n)
        tick_accept |=> event_valid)
        else $error("accepted tick produced no event transaction");

    // The OK key events exclude each other.
    assert property (@(posedge clk) disable iff (!rst_n)
        event_valid |-> $onehot0({events.enter_event, events.quit_event,
                                  events.double_click_event}))
        else $error("more than one OK key event in one tick");

    // Up and down long presses share the counter, so they never fire together.
    assert property (@(posedge clk) disable iff (!rst_n)
        event_valid |-> !(events.up_long_event && events.down_long_event))
        else $error("up and down long press in the same tick");

    // Counters stay at or below the saturation limit and the click stage never reaches three.
    assert property (@(posedge clk) disable iff (!rst_n)
        hold_count_reg <= COUNT_LIMIT && gap_count_reg <= COUNT_LIMIT
        && click_stage_reg != STAGE_THREE)
        else $error("counter beyond limit or unreachable click stage");
`endif

endmodule
